### hw/rtl/lru_page_replacement_defines.svh
// Assertion macros shared by the LRU page replacement RTL.
`ifndef LRU_PAGE_REPLACEMENT_DEFINES_SVH
`define LRU_PAGE_REPLACEMENT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define LRUPR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define LRUPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/lrupr_pkg.sv
// Package with shared constants and types for the LRU page replacement block.
package lrupr_pkg;

  localparam int CNT_W         = 4;
  localparam int FRAMES_DEF    = 8;
  localparam int PAGE_BITS_DEF = 16;

  localparam logic [CNT_W-1:0] FRAME_CNT_RST = CNT_W'(8);

  typedef struct packed {
    logic cfg_wr;
    logic capture;
    logic lookup;
    logic update;
  } cmd_t;

endpackage

### hw/rtl/lrupr_ctrl.sv
// Controller state machine for the LRU page replacement block.
module lrupr_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  output lrupr_pkg::cmd_t  cmd
);
  import lrupr_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LOOKUP = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       in_acc;
  logic       out_free;

  // A pending register write goes first, so a reference never starts in the
  // same cycle as a write to the frame count.
  assign in_stall  = (state_r != ST_IDLE) || cfg_valid;
  assign cfg_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.cfg_wr    = cfg_valid && cfg_ready;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_nxt  = ST_UPDATE;
      end
      ST_UPDATE: begin
        // The result register must be free before the stack is committed.
        if (out_free) begin
          cmd.update    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### hw/rtl/lrupr_dp.sv
// Datapath of the LRU page replacement block: recency stack, lookup and results.
module lrupr_dp #(
  parameter int FRAMES    = lrupr_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lrupr_pkg::cmd_t             cmd,
  input  logic [PAGE_BITS-1:0]        in_page,
  input  logic [lrupr_pkg::CNT_W-1:0] cfg_frame_count,
  output logic                        out_hit,
  output logic                        out_evicted,
  output logic [PAGE_BITS-1:0]        out_victim_page,
  output logic [lrupr_pkg::CNT_W-1:0] out_frames_used
);
  import lrupr_pkg::*;

  localparam int CNT_MAX = (1 << CNT_W) - 1;
  localparam int LIM_MAX = (FRAMES < CNT_MAX) ? FRAMES : CNT_MAX;

  logic [PAGE_BITS-1:0] stack_r   [FRAMES];
  logic [PAGE_BITS-1:0] stack_nxt [FRAMES];

  logic [CNT_W-1:0]     frame_cnt_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [PAGE_BITS-1:0] page_r;

  // Lookup results held between the lookup and update steps.
  logic                 hit_r, grow_r, evict_r;
  logic [CNT_W-1:0]     pos_r;
  logic [PAGE_BITS-1:0] victim_r;

  logic [CNT_W-1:0]     lim_c;
  logic                 hit_c, grow_c;
  logic [CNT_W-1:0]     hit_pos_c, pos_c;
  logic [PAGE_BITS-1:0] victim_c;

  logic                 out_hit_r, out_evicted_r;
  logic [PAGE_BITS-1:0] out_victim_r;
  logic [CNT_W-1:0]     out_used_r;

  always_comb begin
    if (frame_cnt_r == '0) begin
      lim_c = CNT_W'(1);
    end else if (int'(frame_cnt_r) > LIM_MAX) begin
      lim_c = CNT_W'(LIM_MAX);
    end else begin
      lim_c = frame_cnt_r;
    end
  end

  // Parallel compare over the valid entries; the lowest matching slot wins.
  always_comb begin
    hit_c     = 1'b0;
    hit_pos_c = '0;
    victim_c  = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (i < int'(cnt_r) && stack_r[i] == page_r) begin
        hit_c     = 1'b1;
        hit_pos_c = CNT_W'(i);
      end
      if (i == int'(cnt_r) - 1) begin
        victim_c = stack_r[i];
      end
    end
    grow_c = !hit_c && (cnt_r < lim_c);
    if (hit_c) begin
      pos_c = hit_pos_c;
    end else if (grow_c) begin
      pos_c = cnt_r;
    end else begin
      pos_c = cnt_r - CNT_W'(1);
    end
  end

  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      stack_nxt[i] = stack_r[i];
      if (i == 0) begin
        stack_nxt[i] = page_r;
      end else if (i <= int'(pos_r)) begin
        stack_nxt[i] = stack_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      page_r <= in_page;
    end
    if (cmd.lookup) begin
      hit_r    <= hit_c;
      grow_r   <= grow_c;
      evict_r  <= !hit_c && !grow_c;
      pos_r    <= pos_c;
      victim_r <= (!hit_c && !grow_c) ? victim_c : '0;
    end
    if (cmd.update) begin
      for (int i = 0; i < FRAMES; i++) begin
        stack_r[i] <= stack_nxt[i];
      end
      out_hit_r     <= hit_r;
      out_evicted_r <= evict_r;
      out_victim_r  <= victim_r;
      out_used_r    <= cnt_r + CNT_W'(grow_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_cnt_r <= FRAME_CNT_RST;
      cnt_r       <= '0;
    end else begin
      if (cmd.cfg_wr) begin
        frame_cnt_r <= cfg_frame_count;
      end
      if (cmd.update) begin
        cnt_r <= cnt_r + CNT_W'(grow_r);
      end
    end
  end

  assign out_hit         = out_hit_r;
  assign out_evicted     = out_evicted_r;
  assign out_victim_page = out_victim_r;
  assign out_frames_used = out_used_r;

endmodule

### hw/rtl/lru_page_replacement.sv
// Top level of the LRU page replacement block: controller plus datapath.
// A result is registered after its page reference passes the capture, lookup and
// update steps of the controller; a new reference is taken only once the last
// one has left the update step, and a stalled result holds the update step.
// Reset (synchronous, active low) empties the recency stack, sets the frame
// count register to 8 and clears all handshake state.
`include "lru_page_replacement_defines.svh"

module lru_page_replacement #(
  parameter int FRAMES    = lrupr_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // Page reference transactions.
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [PAGE_BITS-1:0]        in_page,
  // Result transactions, one for every reference.
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_hit,
  output logic                        out_evicted,
  output logic [PAGE_BITS-1:0]        out_victim_page,
  output logic [lrupr_pkg::CNT_W-1:0] out_frames_used,
  // Frame count register write transactions.
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [lrupr_pkg::CNT_W-1:0] cfg_frame_count
);
  import lrupr_pkg::*;

  cmd_t cmd;

  // The controller sequences each reference through capture, lookup and
  // update, and owns the valid flag of the result register. Configuration
  // writes are taken only while no reference is in flight.
  lrupr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  // The datapath holds the recency stack, most recent page in slot zero.
  // The lookup step compares the page against every valid slot at once and
  // decides between hit, push into a free frame and eviction of the least
  // recent page; the update step shifts the stack and loads the results.
  lrupr_dp #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_page         (in_page),
    .cfg_frame_count (cfg_frame_count),
    .out_hit         (out_hit),
    .out_evicted     (out_evicted),
    .out_victim_page (out_victim_page),
    .out_frames_used (out_frames_used)
  );

  // A hit never evicts, and a victim is reported only on an eviction.
  `LRUPR_ASSERT_NOW(a_hit_no_evict, out_valid && out_hit, !out_evicted, "hit with eviction")
  `LRUPR_ASSERT_NOW(a_victim_zero, out_valid && !out_evicted, out_victim_page == '0, "stray victim")
  // After any reference at least one page is resident.
  `LRUPR_ASSERT_NOW(a_used_nonzero, out_valid, out_frames_used != '0, "empty after reference")
  // An accepted reference keeps the input side busy in the next cycle.
  `LRUPR_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "no busy after accept")

endmodule
